/* design/morse_character_keyer_assert.svh */
// Assertion macros used by the keyer top level.
`ifndef MORSE_CHARACTER_KEYER_ASSERT_SVH
`define MORSE_CHARACTER_KEYER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MCK_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("keyer assertion failed");

// Next-cycle implication, checked outside reset.
`define MCK_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("keyer assertion failed");

`endif

/* design/mck_pkg.sv */
// -----------------------------------------------------------------------------
// Morse keyer package
// Types, code table and symbol classification shared by the keyer modules.
// -----------------------------------------------------------------------------
package mck_pkg;

  localparam int unsigned ElemW  = 6;  // elements after the marker, at most
  localparam int unsigned CountW = 3;

  localparam logic [7:0] RomBase   = 8'h20;
  localparam logic [7:0] LowerBase = 8'h40;
  localparam logic [7:0] UpperLast = 8'h5A;
  localparam logic [7:0] LowerFrst = 8'h61;
  localparam logic [7:0] LowerLast = 8'h7A;

  localparam logic CmdAscii = 1'b0;
  localparam logic CmdRaw   = 1'b1;

  localparam logic [1:0] OnDot   = 2'd1;
  localparam logic [1:0] OnDash  = 2'd3;
  localparam logic [1:0] OnSpace = 2'd0;
  localparam logic [1:0] OffGap  = 2'd1;
  localparam logic [1:0] OffSpc  = 2'd2;

  localparam logic [7:0] CodeRom [64] = '{
    8'h01, 8'hD7, 8'hA5, 8'h00, 8'h93, 8'h00, 8'h51, 8'hBD,
    8'h6D, 8'hDB, 8'h00, 8'h55, 8'hE7, 8'hC3, 8'hAB, 8'h65,
    8'h7F, 8'h5F, 8'h4F, 8'h47, 8'h43, 8'h41, 8'h61, 8'h71,
    8'h79, 8'h7D, 8'hF1, 8'hD5, 8'h00, 8'h63, 8'h00, 8'h99,
    8'hB5, 8'h0B, 8'h31, 8'h35, 8'h19, 8'h05, 8'h25, 8'h1D,
    8'h21, 8'h09, 8'h2F, 8'h1B, 8'h29, 8'h0F, 8'h0D, 8'h1F,
    8'h2D, 8'h3B, 8'h15, 8'h11, 8'h07, 8'h13, 8'h23, 8'h17,
    8'h33, 8'h37, 8'h39, 8'h00, 8'h00, 8'h00, 8'h00, 8'h9B
  };

  // One classified symbol: elements left-aligned, next one in the top bit.
  typedef struct packed {
    logic [ElemW-1:0]  bits;
    logic [CountW-1:0] count;
    logic              space;
  } mck_entry_t;

endpackage

/* design/mck_if.sv */
// -----------------------------------------------------------------------------
// Keyer channel interfaces
// Valid/ready channels for symbol requests and key elements.
// -----------------------------------------------------------------------------
interface mck_cmd_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] symbol;

  modport source (output valid, output command, output symbol, input ready);
  modport sink   (input valid, input command, input symbol, output ready);
endinterface

interface mck_elem_if;
  logic       valid;
  logic       ready;
  logic [1:0] on_quanta;
  logic [1:0] off_quanta;
  logic       last;

  modport source (output valid, output on_quanta, output off_quanta, output last,
                  input ready);
  modport sink   (input valid, input on_quanta, input off_quanta, input last,
                  output ready);
endinterface

/* design/mck_front.sv */
// -----------------------------------------------------------------------------
// Keyer front end
// Accepts symbols, maps characters to packed codes and splits out elements.
// -----------------------------------------------------------------------------
module mck_front (
  mck_cmd_if.sink              cmd_i,
  output logic                 push_valid_o,
  output mck_pkg::mck_entry_t  push_data_o,
  input  logic                 push_ready_i
);
  import mck_pkg::*;

  logic [7:0]  ch;
  logic [7:0]  up_off;
  logic [7:0]  lo_off;
  logic [7:0]  code;
  logic [2:0]  marker_pos;
  logic [ElemW-1:0] tail;

  assign ch     = cmd_i.symbol;
  assign up_off = ch - RomBase;
  assign lo_off = ch - LowerBase;

  always_comb begin
    priority if (cmd_i.command == CmdRaw) begin
      code = ch;
    end else if (ch >= RomBase && ch <= UpperLast) begin
      code = CodeRom[up_off[5:0]];
    end else if (ch >= LowerFrst && ch <= LowerLast) begin
      code = CodeRom[lo_off[5:0]];
    end else begin
      code = 8'h00;
    end
  end

  // Highest set bit among 7..1 is the marker.
  always_comb begin
    marker_pos = 3'd0;
    for (int i = 1; i < 8; i++) begin
      if (code[i]) marker_pos = 3'(i);
    end
  end

  assign tail = code[ElemW:1] << (3'd7 - marker_pos);

  always_comb begin
    push_data_o.bits  = tail;
    push_data_o.count = (marker_pos == 3'd0) ? '0 : CountW'(marker_pos - 3'd1);
    push_data_o.space = code[0];
  end

  // Drop symbols that key nothing: no element after the marker and no space.
  assign push_valid_o = cmd_i.valid && ((marker_pos > 3'd1) || code[0]);
  assign cmd_i.ready  = push_ready_i;

endmodule

/* design/mck_queue.sv */
// -----------------------------------------------------------------------------
// Keyer element queue
// Small register FIFO between the front end and the element sequencer.
// -----------------------------------------------------------------------------
module mck_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_valid_i,
  input  mck_pkg::mck_entry_t push_data_i,
  output logic                push_ready_o,
  output logic                pop_valid_o,
  output mck_pkg::mck_entry_t pop_data_o,
  input  logic                pop_ready_i
);
  import mck_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  mck_entry_t          mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    unique case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule

/* design/mck_back.sv */
// -----------------------------------------------------------------------------
// Keyer element sequencer
// Steps through one classified symbol and emits one key element per cycle while elem_o is not stalled.
// -----------------------------------------------------------------------------
module mck_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                pop_valid_i,
  input  mck_pkg::mck_entry_t pop_data_i,
  output logic                pop_ready_o,
  mck_elem_if.source          elem_o
);
  import mck_pkg::*;

  logic              busy_q, busy_d;
  logic [ElemW-1:0]  bits_q, bits_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic              spc_q, spc_d;
  logic              out_valid_q, out_valid_d;
  logic [1:0]        on_q, on_d;
  logic [1:0]        off_q, off_d;
  logic              last_q, last_d;
  logic              advance;
  logic              step_last;

  assign advance   = busy_q && (!out_valid_q || elem_o.ready);
  assign step_last = (cnt_q == '0) || (cnt_q == CountW'(1) && !spc_q);
  assign pop_ready_o = !busy_q || (advance && step_last);

  always_comb begin
    busy_d      = busy_q;
    bits_d      = bits_q;
    cnt_d       = cnt_q;
    spc_d       = spc_q;
    out_valid_d = out_valid_q;
    on_d        = on_q;
    off_d       = off_q;
    last_d      = last_q;

    if (advance) begin
      out_valid_d = 1'b1;
      last_d      = step_last;
      if (cnt_q != '0) begin
        on_d   = bits_q[ElemW-1] ? OnDash : OnDot;
        off_d  = OffGap;
        bits_d = bits_q << 1;
        cnt_d  = cnt_q - 1'b1;
      end else begin
        on_d  = OnSpace;
        off_d = OffSpc;
        spc_d = 1'b0;
      end
      if (step_last) busy_d = 1'b0;
    end else if (elem_o.ready) begin
      out_valid_d = 1'b0;
    end

    // Load the next symbol as soon as the current one issues its last element.
    if (pop_valid_i && pop_ready_o) begin
      busy_d = 1'b1;
      bits_d = pop_data_i.bits;
      cnt_d  = pop_data_i.count;
      spc_d  = pop_data_i.space;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bits_q <= bits_d;
    cnt_q  <= cnt_d;
    spc_q  <= spc_d;
    on_q   <= on_d;
    off_q  <= off_d;
    last_q <= last_d;
  end

  assign elem_o.valid      = out_valid_q;
  assign elem_o.on_quanta  = on_q;
  assign elem_o.off_quanta = off_q;
  assign elem_o.last       = last_q;

endmodule

/* design/morse_character_keyer.sv */
// -----------------------------------------------------------------------------
// Morse character keyer
// Turns characters or packed Morse codes into a stream of key elements.
// -----------------------------------------------------------------------------
// Usage:
//   cmd_i  : one request per symbol; command 0 means symbol is an ASCII
//            character (lower case folds to upper), 1 means a raw packed code.
//   elem_o : one key element per item: on/off time in quanta, last marks the
//            final element of the symbol. Symbols that map to no code key
//            nothing and produce no element.
// Path: an accepted request is written into the queue, then loaded into the
//   sequencer, and its first element is registered at elem_o.
// Throughput: one element per cycle while elem_o.ready is high; a symbol has
//   1 to 7 elements, all issued by the single element sequencer. Requests
//   keep being taken while the QueueDepth-entry queue has room, so the next
//   symbol starts in the cycle after the last element.
// Reset: clears the queue and the sequencer; no element is pending.
// Stall: elem_o holds its element while ready is low; the queue then fills
//   and cmd_i.ready drops.
// -----------------------------------------------------------------------------
`include "morse_character_keyer_assert.svh"

module morse_character_keyer #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mck_cmd_if.sink    cmd_i,
  mck_elem_if.source elem_o
);
  import mck_pkg::*;

  logic       push_valid, push_ready;
  mck_entry_t push_data;
  logic       pop_valid, pop_ready;
  mck_entry_t pop_data;

  mck_front u_front (
    .cmd_i        (cmd_i),
    .push_valid_o (push_valid),
    .push_data_o  (push_data),
    .push_ready_i (push_ready)
  );

  mck_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_data_i  (push_data),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_data_o   (pop_data),
    .pop_ready_i  (pop_ready)
  );

  mck_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_data_i  (pop_data),
    .pop_ready_o (pop_ready),
    .elem_o      (elem_o)
  );

  `MCK_ASSERT_IMPLIES(a_elem_legal, clk_i, rst_ni, elem_o.valid,
    (elem_o.on_quanta == OnDot && elem_o.off_quanta == OffGap) ||
    (elem_o.on_quanta == OnDash && elem_o.off_quanta == OffGap) ||
    (elem_o.on_quanta == OnSpace && elem_o.off_quanta == OffSpc && elem_o.last))
  `MCK_ASSERT_IMPLIES(a_queue_nonempty, clk_i, rst_ni, pop_valid,
    (pop_data.count != '0) || pop_data.space)
  `MCK_ASSERT_IMPLIES(a_raw_zero_drop, clk_i, rst_ni,
    cmd_i.valid && cmd_i.command == CmdRaw && cmd_i.symbol == 8'h00, !push_valid)
  `MCK_ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, elem_o.valid && !elem_o.ready,
    elem_o.valid && $stable({elem_o.on_quanta, elem_o.off_quanta, elem_o.last}))

endmodule

/* dv/testbench.sv */
// -----------------------------------------------------------------------------
// Morse keyer testbench
// Drives characters and raw packed codes into the keyer with random gaps on
// both channels, predicts the key elements of each symbol and checks every
// element in order.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import mck_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned NumRandom  = 320;

  // Packed Morse codes for 0x20..0x5F; holes hold zero.
  localparam logic [7:0] CharCodes [64] = '{
    8'h01, 8'hD7, 8'hA5, 8'h00, 8'h93, 8'h00, 8'h51, 8'hBD,
    8'h6D, 8'hDB, 8'h00, 8'h55, 8'hE7, 8'hC3, 8'hAB, 8'h65,
    8'h7F, 8'h5F, 8'h4F, 8'h47, 8'h43, 8'h41, 8'h61, 8'h71,
    8'h79, 8'h7D, 8'hF1, 8'hD5, 8'h00, 8'h63, 8'h00, 8'h99,
    8'hB5, 8'h0B, 8'h31, 8'h35, 8'h19, 8'h05, 8'h25, 8'h1D,
    8'h21, 8'h09, 8'h2F, 8'h1B, 8'h29, 8'h0F, 8'h0D, 8'h1F,
    8'h2D, 8'h3B, 8'h15, 8'h11, 8'h07, 8'h13, 8'h23, 8'h17,
    8'h33, 8'h37, 8'h39, 8'h00, 8'h00, 8'h00, 8'h00, 8'h9B
  };

  typedef struct packed {
    logic [1:0] on_quanta;
    logic [1:0] off_quanta;
    logic       last;
  } key_element_t;

  class key_board;
    key_element_t pending_elements[$];
    int unsigned  mismatch_count;

    function new();
      mismatch_count = 0;
    endfunction

    // Expand one accepted request into its key elements.
    function void note_symbol(logic command, logic [7:0] symbol);
      logic [7:0]   code;
      bit           marker;
      int unsigned  count;
      key_element_t elem;
      marker = 1'b0;
      count  = 0;
      if (command == CmdRaw) begin
        code = symbol;
      end else if (symbol >= RomBase && symbol <= UpperLast) begin
        code = CharCodes[6'(symbol - RomBase)];
      end else if (symbol >= LowerFrst && symbol <= LowerLast) begin
        code = CharCodes[6'(symbol - LowerBase)];
      end else begin
        code = 8'h00;
      end
      for (int b = 7; b >= 1; b--) begin
        if (!marker) begin
          marker = code[b];
        end else begin
          elem.on_quanta  = code[b] ? OnDash : OnDot;
          elem.off_quanta = OffGap;
          elem.last       = 1'b0;
          pending_elements.push_back(elem);
          count++;
        end
      end
      if (code[0]) begin
        elem.on_quanta  = OnSpace;
        elem.off_quanta = OffSpc;
        elem.last       = 1'b0;
        pending_elements.push_back(elem);
        count++;
      end
      if (count > 0) pending_elements[pending_elements.size() - 1].last = 1'b1;
    endfunction

    function void check_element(logic [1:0] on_q, logic [1:0] off_q, logic last);
      key_element_t want;
      if (pending_elements.size() == 0) begin
        $error("unexpected element: on_quanta %0d off_quanta %0d last %0d",
               on_q, off_q, last);
        mismatch_count++;
        return;
      end
      want = pending_elements.pop_front();
      if (on_q !== want.on_quanta) begin
        $error("on_quanta: expected %0d, actual %0d", want.on_quanta, on_q);
        mismatch_count++;
      end
      if (off_q !== want.off_quanta) begin
        $error("off_quanta: expected %0d, actual %0d", want.off_quanta, off_q);
        mismatch_count++;
      end
      if (last !== want.last) begin
        $error("last: expected %0d, actual %0d", want.last, last);
        mismatch_count++;
      end
    endfunction
  endclass

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  bit          quiet_tail = 1'b0;
  int unsigned cycle_count = 0;
  key_board    board;

  mck_cmd_if  cmd_ch ();
  mck_elem_if elem_ch ();

  morse_character_keyer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_ch),
    .elem_o (elem_ch)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && elem_ch.valid && elem_ch.ready) begin
      board.check_element(elem_ch.on_quanta, elem_ch.off_quanta, elem_ch.last);
    end
  end

  // Element sink: random stalls, long open stretches now and then.
  initial begin
    int run;
    int hold;
    elem_ch.ready <= 1'b0;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      run = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 10);
      elem_ch.ready <= 1'b1;
      repeat (run) @(posedge clk_i);
      if (!quiet_tail) begin
        hold = $urandom_range(1, 12);
        elem_ch.ready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
    end
  end

  task automatic send_symbol(input logic cmd, input logic [7:0] sym, input bit may_idle);
    int gap;
    if (may_idle && !quiet_tail && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_ch.valid   <= 1'b1;
    cmd_ch.command <= cmd;
    cmd_ch.symbol  <= sym;
    @(posedge clk_i);
    while (!cmd_ch.ready) @(posedge clk_i);
    board.note_symbol(cmd, sym);
  endtask

  // Hold off requests until every predicted element has come out.
  task automatic wait_drained();
    cmd_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (board.pending_elements.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int         kind;
    int         len;
    logic       cmd;
    logic [7:0] sym;
    board = new();
    cmd_ch.valid   <= 1'b0;
    cmd_ch.command <= CmdAscii;
    cmd_ch.symbol  <= 8'h00;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Raw codes: empty, space only, marker only, longest, no space flag.
    send_symbol(CmdRaw, 8'h00, 1'b1);
    send_symbol(CmdRaw, 8'h01, 1'b1);
    send_symbol(CmdRaw, 8'h02, 1'b1);
    send_symbol(CmdRaw, 8'h03, 1'b1);
    send_symbol(CmdRaw, 8'hFF, 1'b1);
    send_symbol(CmdRaw, 8'h80, 1'b1);
    send_symbol(CmdRaw, 8'hFE, 1'b1);
    send_symbol(CmdRaw, 8'h81, 1'b1);
    send_symbol(CmdRaw, 8'hAA, 1'b1);
    // Characters: table ends, holes, case folding, letter F, unmapped ranges.
    send_symbol(CmdAscii, 8'h20, 1'b1);
    send_symbol(CmdAscii, 8'h23, 1'b1);
    send_symbol(CmdAscii, "F", 1'b1);
    send_symbol(CmdAscii, "f", 1'b1);
    send_symbol(CmdAscii, "A", 1'b1);
    send_symbol(CmdAscii, "Z", 1'b1);
    send_symbol(CmdAscii, "a", 1'b1);
    send_symbol(CmdAscii, "z", 1'b1);
    send_symbol(CmdAscii, "_", 1'b1);
    send_symbol(CmdAscii, 8'h60, 1'b1);
    send_symbol(CmdAscii, 8'h7B, 1'b1);
    send_symbol(CmdAscii, 8'h7F, 1'b1);
    send_symbol(CmdAscii, 8'hFF, 1'b1);
    send_symbol(CmdAscii, 8'h1F, 1'b1);
    send_symbol(CmdAscii, 8'h00, 1'b1);
    send_symbol(CmdAscii, "0", 1'b1);
    send_symbol(CmdAscii, "@", 1'b1);
    wait_drained();

    for (int i = 0; i < NumRandom; i++) begin
      quiet_tail = (i >= NumRandom - 40);
      if (i == NumRandom / 2) wait_drained();
      kind = $urandom_range(0, 9);
      if (kind <= 4) begin
        cmd = CmdAscii;
        sym = 8'($urandom_range(8'h20, 8'h7A));
      end else if (kind == 5) begin
        cmd = CmdAscii;
        sym = 8'($urandom_range(0, 255));
      end else if (kind <= 8) begin
        // well-formed packed code: marker, then len-1 elements and space flag
        cmd = CmdRaw;
        len = $urandom_range(1, 7);
        sym = (8'h01 << len) | (8'($urandom) & ((8'h01 << len) - 8'h01));
      end else begin
        cmd = CmdRaw;
        sym = 8'($urandom_range(0, 255));
      end
      send_symbol(cmd, sym, (i % 64) >= 12);
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (board.mismatch_count == 0 && board.pending_elements.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
